// ----- design/pik_pkg.sv -----
// Shared constants, codes and helper functions for the 2R Newton inverse-kinematics unit.
`default_nettype none
package pik_pkg;

   localparam int MAX_ITERATIONS = 20;
   localparam int CORDIC_STAGES  = 16;
   localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
   localparam int STAGE_W        = $clog2(CORDIC_STAGES);

   localparam int ANGLE_W  = 21;
   localparam int SUM_W    = 22;
   localparam int ANG_W    = 27;
   localparam int TRIG_W   = 20;
   localparam int POS_W    = 21;
   localparam int TGT_W    = 19;
   localparam int ERR_W    = 22;
   localparam int JAC_W    = 20;
   localparam int MUL_W    = 24;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int NUM_W    = 60;
   localparam int DEN_W    = 42;
   localparam int QUO_W    = NUM_W + 1;
   localparam int FRAC_SH  = 14;

   localparam logic signed [ANG_W-1:0] PI_Q20      = 27'sd3294199;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q20  = 27'sd6588398;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 27'sd1647099;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 20'sd39797;

   localparam logic signed [ANGLE_W-1:0] START_ANGLE = 21'sd32768;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX   = 21'sd1048575;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN   = -21'sd1048576;

   localparam logic [1:0] CSR_LINK1 = 2'd0;
   localparam logic [1:0] CSR_LINK2 = 2'd1;
   localparam logic [1:0] CSR_TOL   = 2'd2;

   localparam logic [1:0] ST_CONVERGED = 2'd0;
   localparam logic [1:0] ST_NO_CONV   = 2'd1;
   localparam logic [1:0] ST_SINGULAR  = 2'd2;

   // Arctangent of 2^-i in Q.20 radians.
   function automatic logic [TRIG_W-1:0] atan_q20(input logic [4:0] idx);
      logic [TRIG_W-1:0] r;
      case (idx)
         5'd0:  r = 20'd823550;
         5'd1:  r = 20'd486170;
         5'd2:  r = 20'd256879;
         5'd3:  r = 20'd130396;
         5'd4:  r = 20'd65451;
         5'd5:  r = 20'd32757;
         5'd6:  r = 20'd16383;
         5'd7:  r = 20'd8192;
         5'd8:  r = 20'd4096;
         5'd9:  r = 20'd2048;
         5'd10: r = 20'd1024;
         5'd11: r = 20'd512;
         5'd12: r = 20'd256;
         5'd13: r = 20'd128;
         5'd14: r = 20'd64;
         5'd15: r = 20'd32;
         5'd16: r = 20'd16;
         5'd17: r = 20'd8;
         5'd18: r = 20'd4;
         5'd19: r = 20'd2;
         5'd20: r = 20'd1;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [ANGLE_W-1:0] clamp_angle(
         input logic signed [QUO_W:0] v);
      logic signed [ANGLE_W-1:0] r;
      if (v > $signed({{(QUO_W+1-ANGLE_W){ANGLE_MAX[ANGLE_W-1]}}, ANGLE_MAX}))
         r = ANGLE_MAX;
      else if (v < $signed({{(QUO_W+1-ANGLE_W){ANGLE_MIN[ANGLE_W-1]}}, ANGLE_MIN}))
         r = ANGLE_MIN;
      else
         r = v[ANGLE_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/pik_interfaces.sv -----
// Handshake channel interfaces for request, response and register write.
`default_nettype none
interface pik_req_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] target_x;
   logic signed [16:0] target_y;
   modport source (output valid, target_x, target_y, input ready);
   modport sink   (input valid, target_x, target_y, output ready);
endinterface

interface pik_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] joint1_angle;
   logic signed [20:0] joint2_angle;
   logic [1:0]         status;
   logic [4:0]         iterations_used;
   modport source (output valid, joint1_angle, joint2_angle, status, iterations_used,
                   input ready);
   modport sink   (input valid, joint1_angle, joint2_angle, status, iterations_used,
                   output ready);
endinterface

interface pik_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/planar_2r_newton_inverse_kinematics_unit.sv -----
// Top level: Newton-Raphson inverse kinematics for a planar two-link arm.
// One target item (x, y in Q2.14 m) yields one result item with both joint angles (Q4.16 rad,
// saturating), a status and the number of Newton updates applied. Items are processed one at
// a time; req ready is high only while the unit is idle. Each Newton iteration runs two CORDIC
// passes, each with range reduction, 14 steps of the one shared 24x24 multiplier, and two
// bit-serial divides (60 quotient bits each). With 20 iterations at most, an item ends
// earlier on convergence or a singular Jacobian. Register writes are taken at any time but
// must only be issued while no item is in flight.
`default_nettype none
module planar_2r_newton_inverse_kinematics_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   pik_req_if.sink     req_port,
   pik_rsp_if.source   rsp_port,
   pik_csr_if.sink     csr_port
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SC1  = 3'd1;
   localparam logic [2:0] S_SC2  = 3'd2;
   localparam logic [2:0] S_MAC  = 3'd3;
   localparam logic [2:0] S_DIV1 = 3'd4;
   localparam logic [2:0] S_DIV2 = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   localparam logic [3:0] K_A1C1  = 4'd0;
   localparam logic [3:0] K_A2C12 = 4'd1;
   localparam logic [3:0] K_A1S1  = 4'd2;
   localparam logic [3:0] K_A2S12 = 4'd3;
   localparam logic [3:0] K_TOL   = 4'd4;
   localparam logic [3:0] K_DXDX  = 4'd5;
   localparam logic [3:0] K_DYDY  = 4'd6;
   localparam logic [3:0] K_ERR   = 4'd7;
   localparam logic [3:0] K_J12J  = 4'd8;
   localparam logic [3:0] K_DET   = 4'd9;
   localparam logic [3:0] K_J12DY = 4'd10;
   localparam logic [3:0] K_N1    = 4'd11;
   localparam logic [3:0] K_J21DX = 4'd12;
   localparam logic [3:0] K_N2    = 4'd13;

   localparam int MW = pik_pkg::MUL_W;
   localparam int AW = pik_pkg::ACC_W;
   localparam logic [pik_pkg::ITER_W-1:0] ITER_LAST =
      pik_pkg::ITER_W'(pik_pkg::MAX_ITERATIONS);

   // configuration registers
   logic [15:0]                          link1_ff;
   logic [15:0]                          link2_ff;
   logic [13:0]                          tol_ff;

   logic [2:0]                           state_ff;
   logic [3:0]                           step_ff;
   logic [pik_pkg::ITER_W-1:0]           iter_ff;
   logic [1:0]                           status_ff;
   logic                                 cs_start_ff;
   logic                                 div_start_ff;

   logic signed [pik_pkg::ANGLE_W-1:0]   q1_ff;
   logic signed [pik_pkg::ANGLE_W-1:0]   q2_ff;
   logic signed [pik_pkg::TGT_W-1:0]     tx_ff;
   logic signed [pik_pkg::TGT_W-1:0]     ty_ff;
   logic signed [pik_pkg::TRIG_W-1:0]    s1_ff, c1_ff, s12_ff, c12_ff;
   logic signed [pik_pkg::POS_W-1:0]     xc_ff, yc_ff;
   logic signed [pik_pkg::JAC_W-1:0]     j12_ff, j22_ff;
   logic [31:0]                          tol2_ff;
   logic signed [pik_pkg::PROD_W-1:0]    prod_ff;
   logic signed [AW-1:0]                 acc_ff;
   logic signed [AW-1:0]                 det_ff;
   logic [pik_pkg::NUM_W-1:0]            div_num_ff;
   logic [pik_pkg::DEN_W-1:0]            div_den_ff;
   logic                                 div_neg_ff;

   logic signed [MW-1:0]                 op_a, op_b;
   logic signed [AW-1:0]                 prod_ext, sum, diff, sum_sh, prod_sh;
   logic signed [AW-1:0]                 diff_abs, det_abs;
   logic signed [pik_pkg::ERR_W-1:0]     dx, dy, j11, j21;
   logic signed [pik_pkg::SUM_W-1:0]     cs_angle;
   logic                                 cs_done, div_done;
   logic signed [pik_pkg::TRIG_W-1:0]    cs_sin, cs_cos;
   logic signed [pik_pkg::QUO_W-1:0]     quot;
   logic signed [pik_pkg::QUO_W:0]       q1_next, q2_next;
   logic [pik_pkg::ITER_W-1:0]           iter_inc;
   logic                                 req_fire, rsp_fire;

   function automatic logic signed [pik_pkg::ERR_W-1:0] ERR_EXT(
         input logic signed [pik_pkg::POS_W-1:0] v);
      return $signed({v[pik_pkg::POS_W-1], v});
   endfunction

   function automatic logic signed [MW-1:0] sx(input logic signed [pik_pkg::ERR_W-1:0] v);
      return $signed({{(MW-pik_pkg::ERR_W){v[pik_pkg::ERR_W-1]}}, v});
   endfunction

   function automatic logic signed [MW-1:0] sx_trig(
         input logic signed [pik_pkg::TRIG_W-1:0] v);
      return $signed({{(MW-pik_pkg::TRIG_W){v[pik_pkg::TRIG_W-1]}}, v});
   endfunction

   assign req_fire = req_port.valid && req_port.ready;
   assign rsp_fire = rsp_port.valid && rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         link1_ff <= '0;
         link2_ff <= '0;
         tol_ff   <= 14'd16;
      end else if (csr_port.valid) begin
         case (csr_port.index)
            pik_pkg::CSR_LINK1: link1_ff <= csr_port.data;
            pik_pkg::CSR_LINK2: link2_ff <= csr_port.data;
            pik_pkg::CSR_TOL:   tol_ff   <= csr_port.data[13:0];
            default: ;
         endcase
      end
   end
   assign csr_port.ready = 1'b1;

   assign dx  = ERR_EXT(xc_ff) -
                $signed({{(pik_pkg::ERR_W-pik_pkg::TGT_W){tx_ff[pik_pkg::TGT_W-1]}}, tx_ff});
   assign dy  = ERR_EXT(yc_ff) -
                $signed({{(pik_pkg::ERR_W-pik_pkg::TGT_W){ty_ff[pik_pkg::TGT_W-1]}}, ty_ff});
   assign j11 = -ERR_EXT(yc_ff);
   assign j21 = ERR_EXT(xc_ff);

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         K_A1C1:  begin op_a = $signed({8'b0, link1_ff}); op_b = sx_trig(c1_ff);  end
         K_A2C12: begin op_a = $signed({8'b0, link2_ff}); op_b = sx_trig(c12_ff); end
         K_A1S1:  begin op_a = $signed({8'b0, link1_ff}); op_b = sx_trig(s1_ff);  end
         K_A2S12: begin op_a = $signed({8'b0, link2_ff}); op_b = sx_trig(s12_ff); end
         K_TOL:   begin op_a = $signed({10'b0, tol_ff});  op_b = $signed({10'b0, tol_ff}); end
         K_DXDX:  begin op_a = sx(dx);  op_b = sx(dx);  end
         K_DYDY:  begin op_a = sx(dy);  op_b = sx(dy);  end
         K_ERR:   begin op_a = sx(j11); op_b = sx_trig(j22_ff); end
         K_J12J:  begin op_a = sx_trig(j12_ff); op_b = sx(j21); end
         K_DET:   begin op_a = sx_trig(j22_ff); op_b = sx(dx); end
         K_J12DY: begin op_a = sx_trig(j12_ff); op_b = sx(dy); end
         K_N1:    begin op_a = sx(j11); op_b = sx(dy); end
         K_J21DX: begin op_a = sx(j21); op_b = sx(dx); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod_ext = $signed({{(AW-pik_pkg::PROD_W){prod_ff[pik_pkg::PROD_W-1]}}, prod_ff});
   assign sum      = acc_ff + prod_ext;
   assign diff     = acc_ff - prod_ext;
   assign sum_sh   = sum >>> pik_pkg::FRAC_SH;
   assign prod_sh  = prod_ext >>> pik_pkg::FRAC_SH;
   assign diff_abs = diff[AW-1] ? -diff : diff;
   assign det_abs  = det_ff[AW-1] ? -det_ff : det_ff;

   assign cs_angle = (state_ff == S_SC1) ?
                     $signed({q1_ff[pik_pkg::ANGLE_W-1], q1_ff}) :
                     $signed({q1_ff[pik_pkg::ANGLE_W-1], q1_ff}) +
                     $signed({q2_ff[pik_pkg::ANGLE_W-1], q2_ff});

   assign q1_next  = $signed({q1_ff[pik_pkg::ANGLE_W-1], q1_ff}) -
                     $signed({quot[pik_pkg::QUO_W-1], quot});
   assign q2_next  = $signed({q2_ff[pik_pkg::ANGLE_W-1], q2_ff}) -
                     $signed({quot[pik_pkg::QUO_W-1], quot});
   assign iter_inc = iter_ff + 1'b1;

   pik_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cs_start_ff),
      .angle   (cs_angle),
      .done    (cs_done),
      .sin_out (cs_sin),
      .cos_out (cs_cos)
   );

   pik_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .num_mag  (div_num_ff),
      .den_mag  (div_den_ff),
      .negate   (div_neg_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= K_A1C1;
         iter_ff      <= '0;
         status_ff    <= pik_pkg::ST_NO_CONV;
         cs_start_ff  <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         cs_start_ff  <= 1'b0;
         div_start_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  tx_ff       <= $signed({req_port.target_x, 2'b00});
                  ty_ff       <= $signed({req_port.target_y, 2'b00});
                  q1_ff       <= pik_pkg::START_ANGLE;
                  q2_ff       <= -pik_pkg::START_ANGLE;
                  iter_ff     <= '0;
                  cs_start_ff <= 1'b1;
                  state_ff    <= S_SC1;
               end
            end
            S_SC1: begin
               if (cs_done) begin
                  s1_ff       <= cs_sin;
                  c1_ff       <= cs_cos;
                  cs_start_ff <= 1'b1;
                  state_ff    <= S_SC2;
               end
            end
            S_SC2: begin
               if (cs_done) begin
                  s12_ff   <= cs_sin;
                  c12_ff   <= cs_cos;
                  step_ff  <= K_A1C1;
                  state_ff <= S_MAC;
               end
            end
            S_MAC: begin
               // hold the step on a divide launch, advance otherwise
               if (step_ff != K_N1 && step_ff != K_N2)
                  step_ff <= step_ff + 1'b1;
               case (step_ff)
                  K_A2C12, K_A2S12, K_DYDY, K_J12J, K_J12DY, K_J21DX: acc_ff <= prod_ext;
                  K_A1S1: begin
                     xc_ff  <= sum_sh[pik_pkg::POS_W-1:0];
                     j22_ff <= prod_sh[pik_pkg::JAC_W-1:0];
                  end
                  K_TOL: begin
                     yc_ff  <= sum_sh[pik_pkg::POS_W-1:0];
                     j12_ff <= -prod_sh[pik_pkg::JAC_W-1:0];
                  end
                  K_DXDX: tol2_ff <= {prod_ff[27:0], 4'b0000};
                  K_ERR: begin
                     // stop when the squared error is inside the squared tolerance
                     if (sum < $signed({{(AW-32){1'b0}}, tol2_ff})) begin
                        status_ff <= pik_pkg::ST_CONVERGED;
                        state_ff  <= S_OUT;
                     end
                  end
                  K_DET: begin
                     det_ff <= diff;
                     if (diff == '0) begin
                        status_ff <= pik_pkg::ST_SINGULAR;
                        state_ff  <= S_OUT;
                     end
                  end
                  K_N1, K_N2: begin
                     div_num_ff   <= {diff_abs[pik_pkg::NUM_W-17:0], 16'h0000};
                     div_den_ff   <= det_abs[pik_pkg::DEN_W-1:0];
                     div_neg_ff   <= diff[AW-1] ^ det_ff[AW-1];
                     div_start_ff <= 1'b1;
                     state_ff     <= (step_ff == K_N1) ? S_DIV1 : S_DIV2;
                  end
                  default: ;
               endcase
            end
            S_DIV1: begin
               if (div_done) begin
                  q1_ff    <= pik_pkg::clamp_angle(q1_next);
                  step_ff  <= K_J21DX;
                  state_ff <= S_MAC;
               end
            end
            S_DIV2: begin
               if (div_done) begin
                  q2_ff   <= pik_pkg::clamp_angle(q2_next);
                  iter_ff <= iter_inc;
                  if (iter_inc == ITER_LAST) begin
                     status_ff <= pik_pkg::ST_NO_CONV;
                     state_ff  <= S_OUT;
                  end else begin
                     cs_start_ff <= 1'b1;
                     state_ff    <= S_SC1;
                  end
               end
            end
            S_OUT: begin
               if (rsp_fire)
                  state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_port.ready           = (state_ff == S_IDLE);
   assign rsp_port.valid           = (state_ff == S_OUT);
   assign rsp_port.joint1_angle    = q1_ff;
   assign rsp_port.joint2_angle    = q2_ff;
   assign rsp_port.status          = status_ff;
   assign rsp_port.iterations_used = (7'(iter_ff) > 7'd31) ? 5'd31 : 5'(iter_ff);

   a_noconv_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && status_ff == pik_pkg::ST_NO_CONV) |-> iter_ff == ITER_LAST)
      else $error("no-convergence result before the iteration cap");

   a_cordic_owner: assert property (@(posedge clock) disable iff (reset)
      cs_done |-> (state_ff == S_SC1 || state_ff == S_SC2))
      else $error("sine/cosine finished outside its wait state");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV1 || state_ff == S_DIV2))
      else $error("divide finished outside its wait state");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_port.ready)
      else $error("ready held after an item was accepted");

endmodule
`default_nettype wire

// ----- design/pik_cordic.sv -----
// Iterative sine/cosine: range reduction then one CORDIC rotation per cycle.
`default_nettype none
module pik_cordic (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [pik_pkg::SUM_W-1:0]    angle,
   output logic                                     done,
   output logic signed [pik_pkg::TRIG_W-1:0]        sin_out,
   output logic signed [pik_pkg::TRIG_W-1:0]        cos_out
);

   localparam logic [1:0] CS_IDLE   = 2'd0;
   localparam logic [1:0] CS_REDUCE = 2'd1;
   localparam logic [1:0] CS_ROTATE = 2'd2;
   localparam logic [pik_pkg::STAGE_W-1:0] STAGE_LAST =
      pik_pkg::STAGE_W'(pik_pkg::CORDIC_STAGES - 1);

   logic [1:0]                          state_ff;
   logic                                done_ff;
   logic                                flip_ff;
   logic [pik_pkg::STAGE_W-1:0]         stage_ff;
   logic signed [pik_pkg::ANG_W-1:0]    v_ff;
   logic signed [pik_pkg::TRIG_W-1:0]   x_ff;
   logic signed [pik_pkg::TRIG_W-1:0]   y_ff;

   logic signed [pik_pkg::TRIG_W-1:0]   xs;
   logic signed [pik_pkg::TRIG_W-1:0]   ys;
   logic signed [pik_pkg::ANG_W-1:0]    atan_v;

   assign xs = x_ff >>> stage_ff;
   assign ys = y_ff >>> stage_ff;
   assign atan_v = $signed({{(pik_pkg::ANG_W-pik_pkg::TRIG_W){1'b0}},
                            pik_pkg::atan_q20(5'(stage_ff))});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            CS_IDLE: begin
               if (start) begin
                  v_ff     <= $signed({angle[pik_pkg::SUM_W-1], angle, 4'b0000});
                  state_ff <= CS_REDUCE;
               end
            end
            CS_REDUCE: begin
               // fold by two pi until inside [-pi, pi), then into the right half plane
               if (v_ff >= pik_pkg::PI_Q20) begin
                  v_ff <= v_ff - pik_pkg::TWO_PI_Q20;
               end else if (v_ff < -pik_pkg::PI_Q20) begin
                  v_ff <= v_ff + pik_pkg::TWO_PI_Q20;
               end else begin
                  if (v_ff > pik_pkg::HALF_PI_Q20) begin
                     v_ff    <= v_ff - pik_pkg::PI_Q20;
                     flip_ff <= 1'b1;
                  end else if (v_ff < -pik_pkg::HALF_PI_Q20) begin
                     v_ff    <= v_ff + pik_pkg::PI_Q20;
                     flip_ff <= 1'b1;
                  end else begin
                     flip_ff <= 1'b0;
                  end
                  x_ff     <= pik_pkg::CORDIC_GAIN;
                  y_ff     <= '0;
                  stage_ff <= '0;
                  state_ff <= CS_ROTATE;
               end
            end
            CS_ROTATE: begin
               if (!v_ff[pik_pkg::ANG_W-1]) begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  v_ff <= v_ff - atan_v;
               end else begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  v_ff <= v_ff + atan_v;
               end
               stage_ff <= stage_ff + 1'b1;
               if (stage_ff == STAGE_LAST) begin
                  done_ff  <= 1'b1;
                  state_ff <= CS_IDLE;
               end
            end
            default: state_ff <= CS_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;

endmodule
`default_nettype wire

// ----- design/pik_divider.sv -----
// Bit-serial restoring divider on magnitudes, truncating toward zero.
`default_nettype none
module pik_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [pik_pkg::NUM_W-1:0]         num_mag,
   input  wire logic [pik_pkg::DEN_W-1:0]         den_mag,
   input  wire logic                              negate,
   output logic                                   done,
   output logic signed [pik_pkg::QUO_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(pik_pkg::NUM_W + 1);

   logic                            busy_ff;
   logic                            done_ff;
   logic                            neg_ff;
   logic [CNT_W-1:0]                count_ff;
   logic [pik_pkg::DEN_W-1:0]       rem_ff;
   logic [pik_pkg::DEN_W-1:0]       den_ff;
   logic [pik_pkg::NUM_W-1:0]       quo_ff;

   logic [pik_pkg::DEN_W:0]         rem_sh;
   logic [pik_pkg::DEN_W:0]         rem_sub;
   logic                            fits;

   assign rem_sh  = {rem_ff, quo_ff[pik_pkg::NUM_W-1]};
   assign fits    = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (start) begin
               busy_ff  <= 1'b1;
               count_ff <= CNT_W'(pik_pkg::NUM_W);
               rem_ff   <= '0;
               quo_ff   <= num_mag;
               den_ff   <= den_mag;
               neg_ff   <= negate;
            end
         end else begin
            // shift one dividend bit in, subtract when the divisor fits
            rem_ff   <= fits ? rem_sub[pik_pkg::DEN_W-1:0] : rem_sh[pik_pkg::DEN_W-1:0];
            quo_ff   <= {quo_ff[pik_pkg::NUM_W-2:0], fits};
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule
`default_nettype wire

// ----- bench/planar_2r_newton_inverse_kinematics_unit_test.sv -----
// Testbench for the 2R Newton inverse-kinematics unit: directed and random targets, links and tolerances.
`default_nettype none
module planar_2r_newton_inverse_kinematics_unit_test;

   typedef struct packed {
      logic signed [16:0] x;
      logic signed [16:0] y;
   } target_type;

   typedef struct packed {
      logic signed [20:0] q1;
      logic signed [20:0] q2;
      logic [1:0]         status;
      logic [4:0]         iters;
   } solution_type;

   localparam longint LIMIT = 8000000;
   localparam longint PI20 = 3294199;
   localparam longint TWO_PI20 = 6588398;
   localparam longint HALF_PI20 = 1647099;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pik_req_if req_ch ();
   pik_rsp_if rsp_ch ();
   pik_csr_if csr_ch ();

   planar_2r_newton_inverse_kinematics_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch.sink),
      .rsp_port (rsp_ch.source),
      .csr_port (csr_ch.sink)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // register copies
   longint link1_len = 0;
   longint link2_len = 0;
   longint tol_dist = 16;

   target_type   pending_targets[$];
   solution_type expected_solutions[$];
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           recv_hold = 0;
   int           failures = 0;
   longint       cycles = 0;
   int           sent = 0;
   bit           req_taken = 1'b0;

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_entry(int i);
      longint t[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      return (i < 21) ? t[i] : 0;
   endfunction

   task automatic rotate(input longint ang16, output longint s, output longint c);
      longint a, r, x, y, xs, ys;
      bit flip;
      a = ang16 * 16;
      r = (a + PI20) % TWO_PI20;
      flip = 0;
      x = 39797;
      y = 0;
      if (r < 0) r += TWO_PI20;
      a = r - PI20;
      if (a > HALF_PI20) begin
         a -= PI20;
         flip = 1;
      end else if (a < -HALF_PI20) begin
         a += PI20;
         flip = 1;
      end
      for (int i = 0; i < pik_pkg::CORDIC_STAGES; i++) begin
         xs = fshift(x, i);
         ys = fshift(y, i);
         if (a >= 0) begin
            x -= ys; y += xs; a -= atan_entry(i);
         end else begin
            x += ys; y -= xs; a += atan_entry(i);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   function automatic longint sat_angle(longint v);
      if (v > 1048575) return 1048575;
      if (v < -1048576) return -1048576;
      return v;
   endfunction

   task automatic solve_target(input target_type t, output solution_type o);
      longint tx, ty, tol2, q1, q2, s1, c1, s12, c12, xc, yc, dx, dy;
      longint j11, j12, j21, j22, det, n1, n2;
      int iters;
      logic [1:0] st;
      tx = longint'(t.x) * 4;
      ty = longint'(t.y) * 4;
      tol2 = (tol_dist * 4) * (tol_dist * 4);
      q1 = 32768;
      q2 = -32768;
      st = pik_pkg::ST_NO_CONV;
      iters = pik_pkg::MAX_ITERATIONS;
      for (int i = 0; i < pik_pkg::MAX_ITERATIONS; i++) begin
         rotate(q1, s1, c1);
         rotate(q1 + q2, s12, c12);
         xc = fshift(link1_len * c1 + link2_len * c12, 14);
         yc = fshift(link1_len * s1 + link2_len * s12, 14);
         dx = xc - tx;
         dy = yc - ty;
         if (dx * dx + dy * dy < tol2) begin
            st = pik_pkg::ST_CONVERGED; iters = i; break;
         end
         j11 = -yc;
         j12 = -fshift(link2_len * s12, 14);
         j21 = xc;
         j22 = fshift(link2_len * c12, 14);
         det = j11 * j22 - j12 * j21;
         if (det == 0) begin
            st = pik_pkg::ST_SINGULAR; iters = i; break;
         end
         n1 = j22 * dx - j12 * dy;
         n2 = j11 * dy - j21 * dx;
         q1 = sat_angle(q1 - (n1 * 65536) / det);
         q2 = sat_angle(q2 - (n2 * 65536) / det);
      end
      if (iters > 31) iters = 31;
      o.q1 = q1[20:0];
      o.q2 = q2[20:0];
      o.status = st;
      o.iters = iters[4:0];
   endtask

   task automatic add_target(input target_type t);
      pending_targets = {pending_targets, t};
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.target_x = '0;
      req_ch.target_y = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("planar_2r_newton_inverse_kinematics_unit_test NOT OK");
         $finish;
      end
   end

   // driver: hold the offered item until it is taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_ch.valid || req_taken) begin
            if (pending_targets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.target_x <= pending_targets[0].x;
               req_ch.target_y <= pending_targets[0].y;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         req_taken = 1'b0;
      end
   end

   // receiver, with a long hold-off counted here
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         solution_type o;
         solve_target(pending_targets[0], o);
         expected_solutions = {expected_solutions, o};
         void'(pending_targets.pop_front());
         sent++;
         req_taken = 1'b1;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_solutions.size() == 0) begin
            $display("%0t: unexpected item q1=%0d q2=%0d st=%0d it=%0d", $realtime,
                     rsp_ch.joint1_angle, rsp_ch.joint2_angle, rsp_ch.status,
                     rsp_ch.iterations_used);
            failures++;
         end else begin
            solution_type e;
            e = expected_solutions.pop_front();
            if (e.q1 !== rsp_ch.joint1_angle) begin
               $display("%0t: joint1 expected %0d got %0d", $realtime, e.q1,
                        rsp_ch.joint1_angle);
               failures++;
            end
            if (e.q2 !== rsp_ch.joint2_angle) begin
               $display("%0t: joint2 expected %0d got %0d", $realtime, e.q2,
                        rsp_ch.joint2_angle);
               failures++;
            end
            if (e.status !== rsp_ch.status) begin
               $display("%0t: status expected %0d got %0d", $realtime, e.status,
                        rsp_ch.status);
               failures++;
            end
            if (e.iters !== rsp_ch.iterations_used) begin
               $display("%0t: iterations expected %0d got %0d", $realtime, e.iters,
                        rsp_ch.iterations_used);
               failures++;
            end
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         pik_pkg::CSR_LINK1: link1_len = val;
         pik_pkg::CSR_LINK2: link2_len = val;
         default: tol_dist = val[13:0];
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_targets.size() > 0 || expected_solutions.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_arm(input logic [15:0] l1, input logic [15:0] l2,
                          input logic [15:0] tl);
      drain();
      write_reg(pik_pkg::CSR_LINK1, l1);
      write_reg(pik_pkg::CSR_LINK2, l2);
      write_reg(pik_pkg::CSR_TOL, tl);
   endtask

   function automatic target_type reachable_target();
      target_type t;
      longint reach, r;
      reach = link1_len + link2_len;
      r = (reach > 65535) ? 65535 : reach;
      t.x = $signed(17'($urandom_range(2 * r) - r));
      t.y = $signed(17'($urandom_range(2 * r) - r));
      return t;
   endfunction

   function automatic target_type noise_target();
      target_type t;
      t.x = 17'($urandom);
      t.y = 17'($urandom);
      return t;
   endfunction

   initial begin
      target_type t;
      logic [15:0] l1, l2, tl;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: zero links
      t.x = 17'sd0; t.y = 17'sd0; add_target(t);
      t.x = 17'sd100; t.y = -17'sd100; add_target(t);
      set_arm(16'd16384, 16'd16384, 16'd16);
      t.x = 17'sd16384; t.y = 17'sd16384; add_target(t);
      t.x = 17'sd32767; t.y = 17'sd0; add_target(t);
      t.x = -17'sd65536; t.y = -17'sd65536; add_target(t);
      t.x = 17'sd65535; t.y = 17'sd65535; add_target(t);
      t.x = 17'sd0; t.y = 17'sd0; add_target(t);
      t.x = -17'sd20000; t.y = 17'sd5000; add_target(t);
      set_arm(16'd16384, 16'd8192, 16'd0);
      t.x = 17'sd16000; t.y = 17'sd8000; add_target(t);
      t.x = 17'sd24576; t.y = 17'sd0; add_target(t);
      set_arm(16'hFFFF, 16'hFFFF, 16'h3FFF);
      t.x = 17'sd65535; t.y = -17'sd65536; add_target(t);
      t.x = 17'sd1; t.y = -17'sd1; add_target(t);
      set_arm(16'd0, 16'd20000, 16'd4);
      t.x = 17'sd10000; t.y = 17'sd10000; add_target(t);
      set_arm(16'd20000, 16'd0, 16'd4);
      t.x = 17'sd10000; t.y = -17'sd10000; add_target(t);

      for (int phase = 0; phase < 9; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 7; recv_idle_pct = 48;
         end else if (phase < 6) begin
            send_idle_pct = 48; recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         l1 = 16'($urandom_range(4000, 40000));
         l2 = 16'($urandom_range(4000, 40000));
         tl = 16'($urandom_range(1, 64));
         if (phase == 4) tl = 16'h3FFF;
         if (phase == 7) begin
            l1 = 16'($urandom); l2 = 16'($urandom); tl = 16'($urandom_range(0, 1));
         end
         set_arm(l1, l2, tl);
         if (phase == 2) recv_hold = 12000;
         for (int k = 0; k < 40; k++)
            add_target($urandom_range(9) < 8 ? reachable_target() : noise_target());
      end
      drain();
      if (failures == 0)
         $display("planar_2r_newton_inverse_kinematics_unit_test OK");
      else
         $display("planar_2r_newton_inverse_kinematics_unit_test NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
